@@ hw/rtl/bdb_pkg.sv @@
// Shared request codes, status codes and port widths for the deque/bag block.
package bdb_pkg;

  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;
  localparam int PORT_W   = 32;
  localparam int OCOUNT_W = 5;

  // Request codes carried on func
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_CONTAINS   = 3'd4,
    FN_REMOVE     = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

@@ hw/rtl/bounded_deque_bag_top.sv @@
// Top level: bounded deque/bag sequencer around a circular entry RAM.
// Sequence: push, pop, unused codes and empty searches pass through S_FRONT_RD, S_BACK_RD
//   and S_DONE; contains/remove first scan entries in S_SCAN_RD/S_SCAN_CMP, and remove
//   then shifts each later entry in S_SHIFT_RD/S_SHIFT_WR before those states.
// Throughput: one item at a time, set by the single RAM port and the shared
//   slot/compare unit; a held result stalls.
// Reset: synchronous active-low; queue empty, head at 0; entry RAM is not cleared.
module bounded_deque_bag_top
  import bdb_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [PORT_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STAT_W-1:0]          out_status,
  output logic                       out_found,
  output logic signed [PORT_W-1:0]   out_front_value,
  output logic signed [PORT_W-1:0]   out_back_value,
  output logic [OCOUNT_W-1:0]        out_entry_count,
  output logic                       out_is_empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_FRONT_RD, S_BACK_RD, S_DONE
  } state_t;

  state_t                  state_r;
  logic [IDX_W-1:0]        head_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        pos_r;
  func_t                   func_r;
  logic [VALUE_BITS-1:0]   key_r;
  status_t                 status_r;
  logic                    found_r;
  logic [VALUE_BITS-1:0]   front_r;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic                    out_found_r;
  logic [PORT_W-1:0]       out_front_r;
  logic [PORT_W-1:0]       out_back_r;
  logic [OCOUNT_W-1:0]     out_count_r;
  logic                    out_empty_r;

  logic [CNT_W-1:0]        pos_sel;
  logic [IDX_W-1:0]        slot;
  logic                    match;
  logic                    ram_we;
  logic                    ram_re;
  logic [VALUE_BITS-1:0]   ram_wdata;
  logic [VALUE_BITS-1:0]   ram_rdata;
  logic [VALUE_BITS-1:0]   key_in;
  logic [63:0]             key_wide;
  logic [63:0]             front_wide;
  logic [63:0]             back_wide;
  logic [31:0]             count_wide;
  logic                    in_xfer;
  logic                    out_free;
  logic                    is_full;
  logic                    is_zero;
  logic [CNT_W:0]          pos_p1;
  logic [CNT_W:0]          pos_p2;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_zero  = (count_r == '0);
  assign pos_p1   = (CNT_W+1)'(pos_r) + (CNT_W+1)'(1);
  assign pos_p2   = (CNT_W+1)'(pos_r) + (CNT_W+1)'(2);

  // value kept as its low VALUE_BITS bits, zero-extended from the port
  assign key_wide = {32'd0, in_value};
  assign key_in   = key_wide[VALUE_BITS-1:0];

  // queue position fed to the shared slot unit
  always_comb begin
    case (state_r)
      S_IDLE: begin
        case (in_func)
          FN_PUSH_FRONT: pos_sel = CNT_W'(DEPTH-1);
          FN_POP_FRONT:  pos_sel = CNT_W'(1);
          default:       pos_sel = count_r;
        endcase
      end
      S_SCAN_RD:  pos_sel = pos_r;
      S_SHIFT_RD: pos_sel = pos_p1[CNT_W-1:0];
      S_SHIFT_WR: pos_sel = pos_r;
      S_FRONT_RD: pos_sel = '0;
      S_BACK_RD:  pos_sel = count_r - CNT_W'(1);
      default:    pos_sel = pos_r;
    endcase
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ram_rdata;
    case (state_r)
      S_IDLE: begin
        ram_wdata = key_in;
        ram_we    = in_xfer && !is_full &&
                    (in_func == FN_PUSH_FRONT || in_func == FN_PUSH_BACK);
      end
      S_SCAN_RD, S_SHIFT_RD, S_FRONT_RD, S_BACK_RD: ram_re = 1'b1;
      S_SHIFT_WR: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  bdb_unit #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_unit (
    .head  (head_r),
    .pos   (pos_sel),
    .key   (key_r),
    .data  (ram_rdata),
    .slot  (slot),
    .match (match)
  );

  bdb_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // result formatting
  assign front_wide = 64'(front_r);
  assign back_wide  = 64'(ram_rdata);
  assign count_wide = 32'(count_r);

  // sequencer, queue state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result leaves; S_DONE loads the next one itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            func_r   <= func_t'(in_func);
            key_r    <= key_in;
            found_r  <= 1'b0;
            pos_r    <= '0;
            case (in_func)
              FN_PUSH_FRONT: begin
                state_r <= S_FRONT_RD;
                if (is_full) begin
                  status_r <= ST_PUSH_FULL;
                end else begin
                  status_r <= ST_OK;
                  head_r   <= slot;
                  count_r  <= count_r + CNT_W'(1);
                end
              end
              FN_PUSH_BACK: begin
                state_r <= S_FRONT_RD;
                if (is_full) begin
                  status_r <= ST_PUSH_FULL;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r + CNT_W'(1);
                end
              end
              FN_POP_FRONT: begin
                state_r <= S_FRONT_RD;
                if (is_zero) begin
                  status_r <= ST_POP_EMPTY;
                end else begin
                  status_r <= ST_OK;
                  head_r   <= slot;
                  count_r  <= count_r - CNT_W'(1);
                end
              end
              FN_POP_BACK: begin
                state_r <= S_FRONT_RD;
                if (is_zero) begin
                  status_r <= ST_POP_EMPTY;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r - CNT_W'(1);
                end
              end
              FN_CONTAINS: begin
                status_r <= ST_OK;
                if (is_zero) begin
                  state_r <= S_FRONT_RD;
                end else begin
                  state_r <= S_SCAN_RD;
                end
              end
              FN_REMOVE: begin
                if (is_zero) begin
                  status_r <= ST_NOT_FOUND;
                  state_r  <= S_FRONT_RD;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_SCAN_RD;
                end
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_FRONT_RD;
              end
            endcase
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (match) begin
            found_r <= 1'b1;
            if (func_r == FN_REMOVE) begin
              if (pos_p1 < (CNT_W+1)'(count_r)) begin
                state_r <= S_SHIFT_RD;
              end else begin
                count_r <= count_r - CNT_W'(1);
                state_r <= S_FRONT_RD;
              end
            end else begin
              state_r <= S_FRONT_RD;
            end
          end else if (pos_p1 == (CNT_W+1)'(count_r)) begin
            // scanned every live entry without a hit
            if (func_r == FN_REMOVE) begin
              status_r <= ST_NOT_FOUND;
            end
            state_r <= S_FRONT_RD;
          end else begin
            pos_r   <= pos_p1[CNT_W-1:0];
            state_r <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: state_r <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          pos_r <= pos_p1[CNT_W-1:0];
          if (pos_p2 < (CNT_W+1)'(count_r)) begin
            state_r <= S_SHIFT_RD;
          end else begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_FRONT_RD;
          end
        end
        S_FRONT_RD: state_r <= S_BACK_RD;
        S_BACK_RD: begin
          front_r <= ram_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // back entry sits in the RAM read register until the result moves out
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_found_r  <= found_r;
            out_front_r  <= is_zero ? '0 : front_wide[PORT_W-1:0];
            out_back_r   <= is_zero ? '0 : back_wide[PORT_W-1:0];
            out_count_r  <= count_wide[OCOUNT_W-1:0];
            out_empty_r  <= is_zero;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;

  // occupancy never passes the bound
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a push on a full queue leaves the count alone
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_full && (in_func == FN_PUSH_FRONT || in_func == FN_PUSH_BACK))
      |=> $stable(count_r))
    else $error("push on full changed count");

  // the search phase never writes the store
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CMP) |-> !ram_we)
    else $error("store write during scan");

  // an empty result reports zero front and back values
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_front_r == '0 && out_back_r == '0))
    else $error("empty result with nonzero values");

endmodule

@@ hw/rtl/bdb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bdb_unit.sv @@
// Shared slot/compare unit: circular slot of a queue position and key match.
module bdb_unit #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic [$clog2(DEPTH)-1:0]   head,
  input  logic [$clog2(DEPTH+1)-1:0] pos,
  input  logic [VALUE_BITS-1:0]      key,
  input  logic [VALUE_BITS-1:0]      data,
  output logic [$clog2(DEPTH)-1:0]   slot,
  output logic                       match
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] sum;

  // head + pos wraps at most once while pos is at most DEPTH, so one compare and subtract
  always_comb begin
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) begin
      slot = IDX_W'(sum - SUM_W'(DEPTH));
    end else begin
      slot = IDX_W'(sum);
    end
  end

  assign match = (data == key);

endmodule
